// File: hw/rtl/disk_indicator_sampler_defines.svh
// assertion macros for the disk indicator sampler
// expects clk and arst_n in the scope of the including module
`ifndef DISK_INDICATOR_SAMPLER_DEFINES_SVH
`define DISK_INDICATOR_SAMPLER_DEFINES_SVH

// checked outside reset only
`define DIS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// checked at every edge, reset included
`define DIS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/dis_pkg.sv
// disk indicator sampler: register codes, fixed-point constants, widths
// no dependencies
package dis_pkg;

	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_RADIUS     = 3'd2,
		REG_SPACING    = 3'd3,
		REG_SMOOTH_LEN = 3'd4,
		REG_SHARP_MODE = 3'd5
	} reg_idx_t;

	// sample points: center and the four neighbors
	localparam int NP    = 5;
	localparam int PT_C  = 0;
	localparam int PT_XM = 1;
	localparam int PT_XP = 2;
	localparam int PT_YM = 3;
	localparam int PT_YP = 4;

	// offset magnitude, radicand, root and remainder widths
	localparam int MAG_W  = 33;
	localparam int RAD_W  = 68;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;

	// gradient magnitude and divider widths
	localparam int UW = 34;
	localparam int DW = 2 * UW;

	// cosine in Q30
	localparam logic [31:0] PI_Q30  = 32'd3373259426;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam int TAYLOR_N = 6;
	localparam int TAYLOR_DIV [TAYLOR_N] = '{132, 90, 56, 30, 12, 2};

endpackage

// File: hw/rtl/disk_indicator_sampler.sv
// Disk indicator sampler: one grid point in, one solid fraction out.
// Pipeline of 3 input stages, 34 square root stages, 3 gradient stages,
// FRAC_BITS divider stages, 3 argument stages, 18 cosine stages
// and the output register. Throughput one item per cycle; the whole pipe holds while a
// result waits on m_tready. Reset clears all valid bits and loads the register defaults
// (center 0, radius, spacing and smoothing length 65536, smooth mode).
// depends on dis_pkg and disk_indicator_sampler_defines.svh
`include "disk_indicator_sampler_defines.svh"

module disk_indicator_sampler #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [dis_pkg::REG_IDX_W-1:0]     cfg_idx,
	input  logic [31:0]                       cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [63:0]                       s_tdata,  // point_x [31:0], point_y [63:32]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [((FRAC_BITS+8)/8)*8-1:0]    m_tdata   // indicator [FRAC_BITS:0], zeros above
);
	import dis_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int OW  = F + 1;
	localparam int OTW = ((F + 8) / 8) * 8;
	localparam int PS  = 3 * TAYLOR_N;
	localparam logic [OW-1:0] ONE_FX  = OW'(1) << F;
	localparam logic [OW-1:0] HALF_FX = ONE_FX >> 1;

	typedef struct packed {
		logic [31:0]        x2;
		logic [31:0]        p;
		logic [71:0]        pm;
		logic signed [31:0] acc;
		logic               hi;
		logic [OW-1:0]      ratio;
	} poly_t;

	function automatic logic [MAG_W-1:0] mag35(input logic signed [34:0] v);
		logic signed [34:0] a;
		a = (v < 0) ? -v : v;
		return a[MAG_W-1:0];
	endfunction

	function automatic logic [UW-1:0] mag37(input logic signed [36:0] v);
		logic signed [36:0] a;
		a = (v < 0) ? -v : v;
		return a[UW-1:0];
	endfunction

	// configuration registers
	logic signed [31:0] center_x_q, center_y_q;
	logic [30:0]        radius_q, spacing_q, eps_q;
	logic               sharp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= 31'd65536;
			spacing_q  <= 31'd65536;
			eps_q      <= 31'd65536;
			sharp_q    <= 1'b0;
		end else if (cfg_wen) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_CENTER_X:   center_x_q <= cfg_wdata;
				REG_CENTER_Y:   center_y_q <= cfg_wdata;
				REG_RADIUS:     radius_q   <= cfg_wdata[30:0];
				REG_SPACING:    spacing_q  <= cfg_wdata[30:0];
				REG_SMOOTH_LEN: eps_q      <= cfg_wdata[30:0];
				REG_SHARP_MODE: sharp_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// whole pipe moves unless a finished item is held at the output
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1: offsets of the five sample points from the center
	logic signed [34:0] px_w, py_w, cx_w, cy_w, h_w;
	logic signed [34:0] ex [NP];
	logic signed [34:0] ey [NP];

	assign px_w = 35'(signed'(s_tdata[31:0]));
	assign py_w = 35'(signed'(s_tdata[63:32]));
	assign cx_w = 35'(center_x_q);
	assign cy_w = 35'(center_y_q);
	assign h_w  = 35'({1'b0, spacing_q});

	always_comb begin
		ex[PT_C]  = px_w - cx_w;
		ex[PT_XM] = px_w - h_w - cx_w;
		ex[PT_XP] = px_w + h_w - cx_w;
		ex[PT_YM] = px_w - cx_w;
		ex[PT_YP] = px_w - cx_w;
		ey[PT_C]  = py_w - cy_w;
		ey[PT_XM] = py_w - cy_w;
		ey[PT_XP] = py_w - cy_w;
		ey[PT_YM] = py_w - h_w - cy_w;
		ey[PT_YP] = py_w + h_w - cy_w;
	end

	logic             v_s1;
	logic [MAG_W-1:0] mx_s1 [NP];
	logic [MAG_W-1:0] my_s1 [NP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NP; i++) begin
				mx_s1[i] <= mag35(ex[i]);
				my_s1[i] <= mag35(ey[i]);
			end
		end
	end

	// stage 2: squares
	logic               v_s2;
	logic [2*MAG_W-1:0] sx_s2 [NP];
	logic [2*MAG_W-1:0] sy_s2 [NP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NP; i++) begin
				sx_s2[i] <= (2*MAG_W)'(mx_s1[i]) * (2*MAG_W)'(mx_s1[i]);
				sy_s2[i] <= (2*MAG_W)'(my_s1[i]) * (2*MAG_W)'(my_s1[i]);
			end
		end
	end

	// stage 3: squared distances
	logic             v_s3;
	logic [RAD_W-1:0] rad_s3 [NP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NP; i++) rad_s3[i] <= RAD_W'(sx_s2[i]) + RAD_W'(sy_s2[i]);
		end
	end

	// square root, one result bit per stage for all five points
	logic              sq_v_s    [ROOT_W];
	logic [RAD_W-1:0]  sq_rad_s  [ROOT_W][NP];
	logic [REM_W-1:0]  sq_rem_s  [ROOT_W][NP];
	logic [ROOT_W-1:0] sq_root_s [ROOT_W][NP];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic              v_i;
		logic [RAD_W-1:0]  rad_i  [NP];
		logic [REM_W-1:0]  rem_i  [NP];
		logic [ROOT_W-1:0] root_i [NP];
		logic [REM_W+1:0]  rr     [NP];
		logic [REM_W+1:0]  trial  [NP];
		logic              ge     [NP];

		if (k == 0) begin : g_first
			assign v_i    = v_s3;
			assign rad_i  = rad_s3;
			assign rem_i  = '{default: '0};
			assign root_i = '{default: '0};
		end else begin : g_next
			assign v_i    = sq_v_s[k-1];
			assign rad_i  = sq_rad_s[k-1];
			assign rem_i  = sq_rem_s[k-1];
			assign root_i = sq_root_s[k-1];
		end

		// bring down the next radicand bit pair and try root*4+1
		always_comb begin
			for (int i = 0; i < NP; i++) begin
				rr[i]    = {rem_i[i], rad_i[i][RAD_W-1 -: 2]};
				trial[i] = (REM_W+2)'({root_i[i], 2'b01});
				ge[i]    = rr[i] >= trial[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[k] <= 1'b0;
			else if (adv) sq_v_s[k] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < NP; i++) begin
					sq_rad_s[k][i]  <= {rad_i[i][RAD_W-3:0], 2'b00};
					sq_rem_s[k][i]  <= ge[i] ? REM_W'(rr[i] - trial[i]) : REM_W'(rr[i]);
					sq_root_s[k][i] <= {root_i[i][ROOT_W-2:0], ge[i]};
				end
			end
		end
	end

	// stage 4: signed insideness, band tests, gradient terms
	logic signed [35:0] tv [NP];
	logic signed [35:0] rl [NP];
	logic signed [35:0] hs;
	logic signed [36:0] ux, uy, ax, ay;
	logic signed [37:0] snum, sden;
	logic               sh_one, sh_zero, sm_zero, sm_one;

	assign hs = 36'({1'b0, spacing_q});

	always_comb begin
		for (int i = 0; i < NP; i++) begin
			tv[i] = 36'({1'b0, radius_q}) - 36'({1'b0, sq_root_s[ROOT_W-1][i]});
			rl[i] = (tv[i] < 0) ? '0 : tv[i];
		end
		ux      = 37'(tv[PT_XP]) - 37'(tv[PT_XM]);
		uy      = 37'(tv[PT_YP]) - 37'(tv[PT_YM]);
		ax      = 37'(rl[PT_XP]) - 37'(rl[PT_XM]);
		ay      = 37'(rl[PT_YP]) - 37'(rl[PT_YM]);
		sh_one  = tv[PT_C] >= hs;
		sh_zero = tv[PT_C] <= -hs;
		// smooth ratio numerator 2d + eps with d = -inside, denominator 2 eps
		snum    = 38'({1'b0, eps_q}) - (38'(tv[PT_C]) <<< 1);
		sden    = 38'({eps_q, 1'b0});
		sm_zero = snum <= 0;
		sm_one  = !sm_zero && (snum >= sden);
	end

	logic          v_s4, fix_s4, fixv_s4;
	logic [UW-1:0] mux_s4, muy_s4, max_s4, may_s4;
	logic [31:0]   snum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= sq_v_s[ROOT_W-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fix_s4  <= sharp_q ? (sh_one || sh_zero) : (sm_zero || sm_one);
			fixv_s4 <= sharp_q ? sh_one : sm_one;
			mux_s4  <= mag37(ux);
			muy_s4  <= mag37(uy);
			max_s4  <= mag37(ax);
			may_s4  <= mag37(ay);
			snum_s4 <= snum[31:0];
		end
	end

	// stage 5: gradient products
	logic          v_s5, fix_s5, fixv_s5;
	logic [DW-1:0] uux_s5, uuy_s5, aux_s5, auy_s5;
	logic [31:0]   snum_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			uux_s5  <= DW'(mux_s4) * DW'(mux_s4);
			uuy_s5  <= DW'(muy_s4) * DW'(muy_s4);
			aux_s5  <= DW'(max_s4) * DW'(mux_s4);
			auy_s5  <= DW'(may_s4) * DW'(muy_s4);
			fix_s5  <= fix_s4;
			fixv_s5 <= fixv_s4;
			snum_s5 <= snum_s4;
		end
	end

	// stage 6: sums, forced results, divider operands
	logic [DW-1:0] denom, numer, dn, dd;
	logic          dfix, dfixv;

	always_comb begin
		denom = uux_s5 + uuy_s5;
		numer = aux_s5 + auy_s5;
		if (sharp_q) begin
			dn = numer;
			dd = denom;
			priority if (fix_s5) begin
				dfix  = 1'b1;
				dfixv = fixv_s5;
			end else if (denom == '0) begin
				dfix  = 1'b1;
				dfixv = 1'b0;
			end else if (numer >= denom) begin
				dfix  = 1'b1;
				dfixv = 1'b1;
			end else begin
				dfix  = 1'b0;
				dfixv = 1'b0;
			end
		end else begin
			dn    = DW'(snum_s5);
			dd    = DW'({eps_q, 1'b0});
			dfix  = fix_s5;
			dfixv = fixv_s5;
		end
	end

	logic          v_s6, fix_s6, fixv_s6;
	logic [DW-1:0] num_s6, den_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s6  <= dn;
			den_s6  <= dd;
			fix_s6  <= dfix;
			fixv_s6 <= dfixv;
		end
	end

	// restoring divider, one quotient bit per stage
	logic          dv_v_s    [F];
	logic          dv_fix_s  [F];
	logic          dv_fixv_s [F];
	logic [DW-1:0] dv_rem_s  [F];
	logic [DW-1:0] dv_den_s  [F];
	logic [F-1:0]  dv_q_s    [F];

	for (genvar k = 0; k < F; k++) begin : g_div
		logic          v_i, fix_i, fixv_i, ge;
		logic [DW-1:0] rem_i, den_i;
		logic [F-1:0]  q_i;
		logic [DW:0]   r2;

		if (k == 0) begin : g_first
			assign v_i    = v_s6;
			assign fix_i  = fix_s6;
			assign fixv_i = fixv_s6;
			assign rem_i  = num_s6;
			assign den_i  = den_s6;
			assign q_i    = '0;
		end else begin : g_next
			assign v_i    = dv_v_s[k-1];
			assign fix_i  = dv_fix_s[k-1];
			assign fixv_i = dv_fixv_s[k-1];
			assign rem_i  = dv_rem_s[k-1];
			assign den_i  = dv_den_s[k-1];
			assign q_i    = dv_q_s[k-1];
		end

		assign r2 = {rem_i, 1'b0};
		assign ge = r2 >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[k] <= 1'b0;
			else if (adv) dv_v_s[k] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[k]  <= ge ? DW'(r2 - {1'b0, den_i}) : DW'(r2);
				dv_den_s[k]  <= den_i;
				dv_q_s[k]    <= {q_i[F-2:0], ge};
				dv_fix_s[k]  <= fix_i;
				dv_fixv_s[k] <= fixv_i;
			end
		end
	end

	// stage 7: ratio and folded cosine argument
	logic [OW-1:0] ratio;
	logic          v_s7, hi_s7;
	logic [OW-1:0] ratio_s7;
	logic [F-1:0]  u_s7;

	assign ratio = dv_fix_s[F-1] ? (dv_fixv_s[F-1] ? ONE_FX : '0) : {1'b0, dv_q_s[F-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv) v_s7 <= dv_v_s[F-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ratio_s7 <= ratio;
			hi_s7    <= ratio > HALF_FX;
			u_s7     <= (ratio > HALF_FX) ? F'(ONE_FX - ratio) : F'(ratio);
		end
	end

	// stage 8: x = pi * u in Q30
	logic [31+F:0] pu;
	logic          v_s8, hi_s8;
	logic [OW-1:0] ratio_s8;
	logic [30:0]   x_s8;

	assign pu = (32+F)'(PI_Q30) * (32+F)'(u_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (adv) v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s8     <= pu[F+30:F];
			hi_s8    <= hi_s7;
			ratio_s8 <= ratio_s7;
		end
	end

	// stage 9: x squared in Q30
	logic [61:0]   xx;
	logic          v_s9, hi_s9;
	logic [OW-1:0] ratio_s9;
	logic [31:0]   x2_s9;

	assign xx = 62'(x_s8) * 62'(x_s8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (adv) v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x2_s9    <= xx[61:30];
			hi_s9    <= hi_s8;
			ratio_s9 <= ratio_s8;
		end
	end

	// nested Taylor series: per term multiply, reciprocal multiply, correct and subtract
	logic  po_v_s [PS];
	poly_t po_s   [PS];

	for (genvar j = 0; j < PS; j++) begin : g_poly
		localparam int C         = TAYLOR_DIV[j/3];
		localparam int SH        = 32 + $clog2(C);
		localparam logic [32:0] RCP = 33'((65'd1 << SH) / C);

		logic  v_i;
		poly_t pi_w, nx;

		if (j == 0) begin : g_first
			assign v_i  = v_s9;
			assign pi_w = '{x2: x2_s9, p: '0, pm: '0, acc: 32'(ONE_Q30),
				hi: hi_s9, ratio: ratio_s9};
		end else begin : g_next
			assign v_i  = po_v_s[j-1];
			assign pi_w = po_s[j-1];
		end

		if (j % 3 == 0) begin : g_mul
			logic [62:0] prod;
			always_comb begin
				nx   = pi_w;
				prod = 63'(pi_w.x2) * 63'(pi_w.acc[30:0]);
				nx.p = prod[61:30];
			end
		end else if (j % 3 == 1) begin : g_rcp
			always_comb begin
				nx    = pi_w;
				nx.pm = 72'(pi_w.p) * 72'(RCP);
			end
		end else begin : g_fix
			logic [31:0] q0, r, q;
			always_comb begin
				nx     = pi_w;
				q0     = pi_w.pm[SH+31:SH];
				r      = pi_w.p - 32'(64'(q0) * 64'(C));
				q      = q0 + 32'(r >= 32'(C));
				nx.acc = 32'(ONE_Q30) - q;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) po_v_s[j] <= 1'b0;
			else if (adv) po_v_s[j] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (adv) po_s[j] <= nx;
		end
	end

	// stage 10: 1 +/- cos, clamp, round to the output scale, mode select
	logic signed [33:0] vv;
	logic [32:0]        vc, w;
	logic [F+1:0]       rnd;
	logic [OW-1:0]      sm_out, ind;

	always_comb begin
		vv = po_s[PS-1].hi ? (34'(ONE_Q30) - 34'(po_s[PS-1].acc))
			: (34'(ONE_Q30) + 34'(po_s[PS-1].acc));
		priority if (vv < 0) vc = '0;
		else if (vv > 34'(33'd1 << 31)) vc = 33'd1 << 31;
		else vc = vv[32:0];
		w      = vc + (33'd1 << (30 - F));
		rnd    = w[32:31-F];
		sm_out = (rnd > (F+2)'(ONE_FX)) ? ONE_FX : OW'(rnd);
		ind    = sharp_q ? po_s[PS-1].ratio : sm_out;
	end

	logic          v_s10;
	logic [OW-1:0] ind_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else if (adv) v_s10 <= po_v_s[PS-1];
	end

	always_ff @(posedge clk) begin
		if (adv) ind_s10 <= ind;
	end

	assign m_tvalid = v_s10;
	assign m_tdata  = OTW'(ind_s10);

	// checks
	`DIS_ASSERT(a_ind_range, m_tvalid |-> (m_tdata[OW-1:0] <= ONE_FX), "indicator above one")
	`DIS_ASSERT(a_stall_hold, !adv |=> ($stable(v_s4) && $stable(v_s7)), "pipe moved in stall")
	`DIS_ASSERT(a_div_rem, (dv_v_s[F-1] && !dv_fix_s[F-1]) |-> (dv_rem_s[F-1] < dv_den_s[F-1]),
		"divider remainder not below divisor")
	`DIS_ASSERT_ALWAYS(a_rst_empty, !arst_n |-> (!m_tvalid && !v_s1), "valid bits set in reset")

endmodule

// File: tb/sv/tb_disk_indicator_sampler.sv
`timescale 1ns / 1ps
// self-checking testbench for disk_indicator_sampler: directed table, then random phases
// depends on dis_pkg and the disk_indicator_sampler rtl; predicts every indicator itself
module tb_disk_indicator_sampler;
	import dis_pkg::*;

	localparam int FB = 16;
	localparam int OUT_W = ((FB + 8) / 8) * 8;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam longint unsigned Q30 = 64'd1 << 30;
	localparam longint ONE_OUT = 64'd1 << FB;
	localparam longint CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;

	typedef logic [127:0] wide_t;

	logic clk, arst_n;
	logic cfg_wen;
	logic [REG_IDX_W-1:0] cfg_idx;
	logic [31:0] cfg_wdata;
	logic s_tvalid, s_tready;
	logic [63:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [OUT_W-1:0] m_tdata;

	disk_indicator_sampler #(.FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// shadow copy of the circle registers
	longint circ_cx, circ_cy, circ_rad, circ_h, circ_eps;
	bit circ_sharp;

	logic [FB:0] indicator_q [$];
	int mismatches, checked, items_sent;
	bit no_idle, hold_req;
	longint cycles = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// exact floor(sqrt) of a radicand up to 2^68
	function automatic longint isqrt(wide_t s);
		wide_t res, c;
		res = 0;
		for (int b = 35; b >= 0; b--) begin
			c = res | (wide_t'(1) << b);
			if (c * c <= s) res = c;
		end
		return longint'(res);
	endfunction

	function automatic longint radial_dist(longint dx, longint dy);
		wide_t ax, ay;
		ax = wide_t'(dx < 0 ? -dx : dx);
		ay = wide_t'(dy < 0 ? -dy : dy);
		return isqrt(ax * ax + ay * ay);
	endfunction

	// radius minus distance, positive inside the disk
	function automatic longint pt_depth(longint px, longint py);
		return circ_rad - radial_dist(px - circ_cx, py - circ_cy);
	endfunction

	// cos(pi*u) in q30, taylor series in nested form
	function automatic longint cos_pi_q30(longint unsigned u);
		longint unsigned x, x2, acc;
		x = (longint'(PI_Q30) * u) >> FB;
		x2 = (x * x) >> 30;
		acc = Q30 - x2 / TAYLOR_DIV[0];
		for (int k = 1; k < TAYLOR_N - 1; k++)
			acc = Q30 - ((x2 * acc) >> 30) / TAYLOR_DIV[k];
		return longint'(Q30) - longint'(((x2 * acc) >> 30) / TAYLOR_DIV[TAYLOR_N-1]);
	endfunction

	function automatic longint smooth_fraction(longint d);
		longint num, den, t, v, o;
		num = 2 * d + circ_eps;
		den = 2 * circ_eps;
		if (num <= 0) t = 0;
		else if (num >= den) t = ONE_OUT;
		else t = (num << FB) / den;
		if (t <= ONE_OUT / 2) v = longint'(Q30) + cos_pi_q30(t);
		else v = longint'(Q30) - cos_pi_q30(ONE_OUT - t);
		if (v < 0) v = 0;
		if (v > 2 * longint'(Q30)) v = 2 * longint'(Q30);
		o = (v + (64'd1 << (30 - FB))) >> (31 - FB);
		return o > ONE_OUT ? ONE_OUT : o;
	endfunction

	function automatic wide_t mag_prod(longint a, longint b);
		return wide_t'(a < 0 ? -a : a) * wide_t'(b < 0 ? -b : b);
	endfunction

	function automatic longint sharp_fraction(longint px, longint py);
		longint tc, txm, txp, tym, typ, ux, uy, ax, ay;
		wide_t numer, denom;
		tc = pt_depth(px, py);
		if (tc >= circ_h) return ONE_OUT;
		if (tc <= -circ_h) return 0;
		txm = pt_depth(px - circ_h, py);
		txp = pt_depth(px + circ_h, py);
		tym = pt_depth(px, py - circ_h);
		typ = pt_depth(px, py + circ_h);
		ux = txp - txm;
		uy = typ - tym;
		ax = (txp < 0 ? 0 : txp) - (txm < 0 ? 0 : txm);
		ay = (typ < 0 ? 0 : typ) - (tym < 0 ? 0 : tym);
		denom = mag_prod(ux, ux) + mag_prod(uy, uy);
		numer = mag_prod(ax, ux) + mag_prod(ay, uy);
		if (denom == 0) return 0;
		if (denom <= numer) return ONE_OUT;
		return longint'((numer << FB) / denom);
	endfunction

	function automatic logic [FB:0] predict_indicator(int px, int py);
		if (circ_sharp) return (FB+1)'(sharp_fraction(longint'(px), longint'(py)));
		return (FB+1)'(smooth_fraction(-pt_depth(longint'(px), longint'(py))));
	endfunction

	// register write, mirrored into the shadow copy
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_CENTER_X:   circ_cx = longint'($signed(val));
			REG_CENTER_Y:   circ_cy = longint'($signed(val));
			REG_RADIUS:     circ_rad = longint'(val[30:0]);
			REG_SPACING:    circ_h = longint'(val[30:0]);
			REG_SMOOTH_LEN: circ_eps = longint'(val[30:0]);
			REG_SHARP_MODE: circ_sharp = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (indicator_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// one point, pushed into the expectation queue when accepted
	task automatic send_point(int px, int py, bit chk, int expv);
		int gap;
		logic [FB:0] pred;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {py, px};
		do @(posedge clk); while (!s_tready);
		pred = predict_indicator(px, py);
		if (chk && pred != expv[FB:0] && mismatches < 10)
			$display("directed row (%0d,%0d): table %0d, predictor %0d", px, py, expv, pred);
		if (chk && pred != expv[FB:0]) mismatches++;
		indicator_q.push_back(chk ? expv[FB:0] : pred);
		items_sent++;
	endtask

	// point near the circle edge, or anywhere
	function automatic int pick_coord_pair(output int py);
		longint span, dx, dy, r2;
		if ($urandom_range(0, 3) == 0) begin
			py = $urandom;
			return $urandom;
		end
		span = circ_rad + 2 * circ_h + 16;
		if (span > 64'h1_0000_0000) span = 64'h1_0000_0000;
		dx = longint'({$urandom, $urandom} % (2 * span + 1)) - span;
		r2 = circ_rad * circ_rad - dx * dx;
		dy = r2 > 0 ? isqrt(wide_t'(r2)) : 0;
		dy = dy + longint'($urandom_range(0, 32)) * (circ_h / 8 + 1) - 16 * (circ_h / 8 + 1);
		if ($urandom_range(0, 1)) dy = -dy;
		py = int'(circ_cy + dy);
		return int'(circ_cx + dx);
	endfunction

	// receiver: random stalls plus one long hold
	initial begin
		int w;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			w = no_idle ? 0 : $urandom_range(0, 5);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready) && !hold_req);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (indicator_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected indicator %0d", m_tdata);
			end else begin
				logic [FB:0] e;
				e = indicator_q.pop_front();
				checked++;
				if (m_tdata != OUT_W'(e)) begin
					mismatches++;
					if (mismatches <= 10)
						$display("indicator mismatch: expected %0d, got %0d", e, m_tdata);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	typedef struct {
		bit sharp;
		int rad, h, eps;
		int px, py;
		bit chk;
		int expv;
	} dir_row_t;

	localparam int IMAX = 32'h7FFF_FFFF;
	localparam int IMIN = 32'h8000_0000;

	dir_row_t dir_rows [] = '{
		'{0, 65536, 65536, 65536, 0, 0, 1, 65536},
		'{0, 65536, 65536, 65536, IMAX, IMAX, 1, 0},
		'{0, 65536, 65536, 65536, IMIN, IMIN, 1, 0},
		'{0, 65536, 65536, 65536, IMAX, IMIN, 1, 0},
		'{0, 65536, 65536, 65536, 65536, 0, 0, 0},
		'{0, 65536, 65536, 65536, 0, -65536, 0, 0},
		'{0, 65536, 65536, 65536, 32768, 0, 0, 0},
		'{0, 65536, 65536, 0, 0, 0, 1, 65536},
		'{0, 65536, 65536, 0, 65536, 0, 0, 0},
		'{0, 65536, 65536, 0, 70000, 0, 1, 0},
		'{0, 0, 65536, 65536, 0, 0, 0, 0},
		'{1, 65536, 65536, 65536, 0, 0, 1, 65536},
		'{1, 65536, 65536, 65536, IMAX, IMAX, 1, 0},
		'{1, 65536, 65536, 65536, IMIN, IMAX, 1, 0},
		'{1, 65536, 65536, 65536, 65536, 0, 0, 0},
		'{1, 65536, 65536, 65536, 60000, 30000, 0, 0},
		'{1, 65536, 65536, 65536, -40000, -50000, 0, 0},
		'{1, 0, 65536, 65536, 0, 0, 1, 0},
		'{1, 65536, 0, 65536, 0, 0, 1, 65536},
		'{1, 65536, 0, 65536, 200000, 0, 1, 0}
	};

	initial begin
		int px, py, n_phase;
		logic [31:0] v;
		// reset falls after time zero so the dut sees the edge
		#0.5 arst_n = 1'b0;
		cfg_wen <= 1'b0;
		cfg_idx <= '0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		mismatches = 0;
		checked = 0;
		items_sent = 0;
		no_idle = 0;
		hold_req = 0;
		circ_cx = 0; circ_cy = 0;
		circ_rad = 65536; circ_h = 65536; circ_eps = 65536;
		circ_sharp = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reconfiguring only when drained
		foreach (dir_rows[i]) begin
			if (dir_rows[i].sharp != circ_sharp || dir_rows[i].rad != circ_rad ||
					dir_rows[i].h != circ_h || dir_rows[i].eps != circ_eps) begin
				s_tvalid <= 1'b0;
				drain();
				write_reg(REG_RADIUS, dir_rows[i].rad);
				write_reg(REG_SPACING, dir_rows[i].h);
				write_reg(REG_SMOOTH_LEN, dir_rows[i].eps);
				write_reg(REG_SHARP_MODE, 32'(dir_rows[i].sharp));
			end
			send_point(dir_rows[i].px, dir_rows[i].py, dir_rows[i].chk, dir_rows[i].expv);
		end

		// random phases, each with its own circle
		n_phase = 9;
		for (int p = 0; p < n_phase; p++) begin
			s_tvalid <= 1'b0;
			drain();
			no_idle = (p == 8);
			write_reg(REG_CENTER_X, (p == 4) ? 32'h8000_0000 : (p == 5) ? 32'h7FFF_FFFF :
				$urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 22) - (1 << 21));
			write_reg(REG_CENTER_Y, (p == 4) ? 32'h8000_0000 : (p == 5) ? 32'h7FFF_FFFF :
				$urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 22) - (1 << 21));
			v = {1'($urandom_range(0, 1)), 31'($urandom_range(1 << 14, 1 << 22))};
			if (p == 4 || p == 5) v = 32'hFFFF_FFFF;
			if (p == 6) v = 32'h8000_0000;
			write_reg(REG_RADIUS, v);
			v = {1'($urandom_range(0, 1)), 31'($urandom_range(1, 1 << 16))};
			if (p == 3) v = 32'h8000_0000;
			if (p == 5) v = 32'h7FFF_FFFF;
			write_reg(REG_SPACING, v);
			v = {1'($urandom_range(0, 1)), 31'($urandom_range(1, 1 << 18))};
			if (p == 2) v = 32'h0;
			if (p == 4) v = 32'hFFFF_FFFF;
			write_reg(REG_SMOOTH_LEN, v);
			write_reg(p == 0 ? REG_SPARE_6 : REG_SPARE_7, $urandom);
			write_reg(REG_SHARP_MODE, {$urandom_range(0, 1) ? $urandom : 32'h0} |
				((p == 1 || p == 3 || p >= 5) ? 32'h1 : 32'h0) &
				((p == 0 || p == 2 || p == 4 || p == 7) ? 32'hFFFF_FFFE : 32'hFFFF_FFFF));
			for (int k = 0; k < 115; k++) begin
				if (p == 7 && k == 10) hold_req = 1'b1;
				px = pick_coord_pair(py);
				send_point(px, py, 0, 0);
			end
		end
		s_tvalid <= 1'b0;

		while (indicator_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("sent %0d points over smooth and sharp circles, %0d indicators checked",
			items_sent, checked);
		$display("settings included zero and full-scale radius, spacing and smoothing");
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
